// ----- hw/rtl/bfsm_pkg.sv -----
// Shared constants, register indexes and result type of the substring match unit.
`default_nettype none
package bfsm_pkg;

    localparam int PATTERN_MAX  = 16;
    localparam int INDEX_BITS   = 16;
    localparam int POS_BITS     = 16;
    localparam int BYTE_BITS    = 8;
    localparam int LEN_BITS     = 5;
    localparam int PAT_SEL_BITS = $clog2(PATTERN_MAX);
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 64;
    localparam int OUT_DATA_BITS = 24;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_PATTERN_LENGTH = 3'd0,
        REG_PATTERN_LOW    = 3'd1,
        REG_PATTERN_HIGH   = 3'd2,
        REG_START_OFFSET   = 3'd3
    } t_cfg_reg;

    typedef struct packed {
        logic                done_res;
        logic [POS_BITS-1:0] match_position;
        logic                found;
    } t_result;

endpackage
`default_nettype wire

// ----- hw/rtl/bfsm_cell.sv -----
// One window cell: holds a text byte, hands it to the next cell, compares with its pattern byte.
`default_nettype none
module bfsm_cell
    import bfsm_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_clear,
    input  wire logic                 i_shift,
    input  wire logic [BYTE_BITS-1:0] i_byte,
    input  wire logic [BYTE_BITS-1:0] i_pat,
    input  wire logic                 i_active,
    output logic      [BYTE_BITS-1:0] o_byte,
    output logic                      o_match
);

    logic [BYTE_BITS-1:0] r_byte;
    logic [BYTE_BITS-1:0] n_byte;

    always_comb begin
        n_byte = r_byte;
        if (i_clear) begin
            n_byte = '0;
        end else if (i_shift) begin
            n_byte = i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else begin
            r_byte <= n_byte;
        end
    end

    // Compare the byte about to enter this cell; cells beyond the length always agree.
    assign o_match = !i_active || (i_byte == i_pat);
    assign o_byte  = r_byte;

endmodule
`default_nettype wire

// ----- hw/rtl/bfsm_out_buf.sv -----
// Output register with a skid stage for result words.
`default_nettype none
module bfsm_out_buf
    import bfsm_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    output logic         o_ready,
    output logic         o_valid,
    input  wire logic    i_take_ready,
    output t_result      o_data
);

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    take;

    assign take = r_out_valid && i_take_ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (i_push) begin
            if (!r_out_valid || take) begin
                n_out       = i_data;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = i_data;
                n_skid_valid = 1'b1;
            end
        end else if (take) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
`default_nettype wire

// ----- hw/rtl/brute_force_substring_match_unit.sv -----
// Top level of the streaming brute-force substring match unit.
`default_nettype none
// Searches a streamed text for a pattern of 1 to 16 bytes. Text bytes enter on the
// slave stream, one word per byte, with tlast on the final byte of each text. Bytes
// at text index start_offset and beyond shift into a row of sixteen cells; every cell
// compares the byte it is about to take with its pattern byte, and the AND of the row
// decides a hit in the same cycle. Each input word yields exactly one result word:
// tdata[0] is the sticky found flag, tdata[16:1] the index of the first match start
// (65535 once the index saturates), tlast the done mark. The result for the tlast
// byte clears the search state; registers are kept. The unit takes one byte per
// clock: the compare row is combinational and an output register plus a skid
// stage decouple the result side, so input only stalls when both hold words.
// Write the configuration port only while no text is in flight.
module brute_force_substring_match_unit
    import bfsm_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // configuration write port
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_wdata,
    // text stream
    input  wire logic                     i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  wire logic [7:0]               i_s_axis_tdata,   // [7:0] text_byte
    input  wire logic                     i_s_axis_tlast,   // text_last
    // result stream
    output logic                          o_m_axis_tvalid,
    input  wire logic                     i_m_axis_tready,
    output logic [OUT_DATA_BITS-1:0]      o_m_axis_tdata,   // [0] found, [16:1] match_position
    output logic                          o_m_axis_tlast    // done_res
);

    localparam logic [INDEX_BITS-1:0] IDX_MAX = '1;
    localparam logic [POS_BITS-1:0]   POS_MAX = '1;

    // Configuration registers
    logic [LEN_BITS-1:0]         r_pattern_length;
    logic [CFG_DATA_BITS-1:0]    r_pattern_low;
    logic [CFG_DATA_BITS-1:0]    r_pattern_high;
    logic [INDEX_BITS-1:0]       r_start_offset;

    // Search state
    logic [LEN_BITS-1:0]         r_fill, n_fill;
    logic [INDEX_BITS-1:0]       r_text_index, n_text_index;
    logic                        r_found, n_found;
    logic [POS_BITS-1:0]         r_first, n_first;

    logic                        accept;
    logic                        in_window;
    logic                        at_max;
    logic [LEN_BITS-1:0]         len;
    logic [LEN_BITS-1:0]         fill_next;
    logic [2*CFG_DATA_BITS-1:0]  pattern;
    logic [PATTERN_MAX-1:0]      cell_match;
    logic [BYTE_BITS-1:0]        cell_in  [PATTERN_MAX];
    logic [BYTE_BITS-1:0]        cell_out [PATTERN_MAX];
    logic                        cell_shift;
    logic                        cell_clear;
    logic                        new_hit;
    logic                        found_now;
    logic [POS_BITS-1:0]         first_now;
    logic [POS_BITS-1:0]         hit_pos;
    logic                        buf_ready;
    t_result                     result;
    t_result                     out_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_length <= LEN_BITS'(1);
            r_pattern_low    <= '0;
            r_pattern_high   <= '0;
            r_start_offset   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PATTERN_LENGTH: r_pattern_length <= i_cfg_wdata[LEN_BITS-1:0];
                REG_PATTERN_LOW:    r_pattern_low    <= i_cfg_wdata;
                REG_PATTERN_HIGH:   r_pattern_high   <= i_cfg_wdata;
                REG_START_OFFSET:   r_start_offset   <= i_cfg_wdata[INDEX_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the length: zero acts as one, anything above the row size as the row size.
    always_comb begin
        len = r_pattern_length;
        if (r_pattern_length == '0) begin
            len = LEN_BITS'(1);
        end else if (r_pattern_length > LEN_BITS'(PATTERN_MAX)) begin
            len = LEN_BITS'(PATTERN_MAX);
        end
    end

    assign pattern         = {r_pattern_high, r_pattern_low};
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = buf_ready;
    assign in_window       = r_text_index >= r_start_offset;
    assign at_max          = r_text_index == IDX_MAX;
    assign fill_next       = (r_fill < LEN_BITS'(PATTERN_MAX)) ? r_fill + LEN_BITS'(1) : r_fill;
    assign cell_clear      = accept && i_s_axis_tlast;
    assign cell_shift      = accept && in_window && !i_s_axis_tlast;

    // Row of cells: cell 0 takes the incoming byte, cell k the byte of cell k-1.
    // Cell k lines up with pattern byte len-1-k.
    for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
        logic [LEN_BITS-1:0]     pat_sel;
        logic                    active;

        assign pat_sel = len - LEN_BITS'(1) - LEN_BITS'(k);
        assign active  = LEN_BITS'(k) < len;

        if (k == 0) begin : g_head
            assign cell_in[k] = i_s_axis_tdata;
        end else begin : g_body
            assign cell_in[k] = cell_out[k-1];
        end

        bfsm_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_clear  (cell_clear),
            .i_shift  (cell_shift),
            .i_byte   (cell_in[k]),
            .i_pat    (pattern[pat_sel[PAT_SEL_BITS-1:0]*BYTE_BITS +: BYTE_BITS]),
            .i_active (active),
            .o_byte   (cell_out[k]),
            .o_match  (cell_match[k])
        );
    end

    // Match start; the window is full enough here, so no underflow.
    assign hit_pos   = at_max ? POS_MAX
                              : POS_BITS'(r_text_index - INDEX_BITS'(len - LEN_BITS'(1)));
    assign new_hit   = accept && in_window && (fill_next >= len) && !r_found && (&cell_match);
    assign found_now = r_found || new_hit;
    assign first_now = new_hit ? hit_pos : r_first;

    always_comb begin
        n_fill       = r_fill;
        n_text_index = r_text_index;
        n_found      = r_found;
        n_first      = r_first;
        if (accept) begin
            if (i_s_axis_tlast) begin
                // Drop the search state for the next text.
                n_fill       = '0;
                n_text_index = '0;
                n_found      = 1'b0;
                n_first      = '0;
            end else begin
                if (in_window) begin
                    n_fill = fill_next;
                end
                if (!at_max) begin
                    n_text_index = r_text_index + INDEX_BITS'(1);
                end
                n_found = found_now;
                n_first = first_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= '0;
            r_text_index <= '0;
            r_found      <= 1'b0;
            r_first      <= '0;
        end else begin
            r_fill       <= n_fill;
            r_text_index <= n_text_index;
            r_found      <= n_found;
            r_first      <= n_first;
        end
    end

    always_comb begin
        result.found          = found_now;
        result.match_position = found_now ? first_now : '0;
        result.done_res       = i_s_axis_tlast;
    end

    bfsm_out_buf u_out_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (accept),
        .i_data       (result),
        .o_ready      (buf_ready),
        .o_valid      (o_m_axis_tvalid),
        .i_take_ready (i_m_axis_tready),
        .o_data       (out_word)
    );

    assign o_m_axis_tdata = {{(OUT_DATA_BITS-POS_BITS-1){1'b0}},
                             out_word.match_position, out_word.found};
    assign o_m_axis_tlast = out_word.done_res;

endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking testbench for the streaming substring match unit.
`timescale 1ns / 1ps

module tb_top;
    import bfsm_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int ITEMS_PER_PHASE = 400;
    localparam int PHASE_COUNT     = 4;
    localparam int REG_COUNT       = 4;
    localparam int PAD_BITS        = OUT_DATA_BITS - POS_BITS - 1;
    localparam int REPORT_CAP      = 100;
    localparam logic [INDEX_BITS-1:0] INDEX_TOP = '1;

    // Tracks the search state of the unit and the result words it owes.
    class match_tracker;
        logic [LEN_BITS-1:0]      len_reg;
        logic [CFG_DATA_BITS-1:0] pat_low;
        logic [CFG_DATA_BITS-1:0] pat_high;
        logic [INDEX_BITS-1:0]    offset_reg;
        logic [BYTE_BITS-1:0]     window [PATTERN_MAX];
        int unsigned              fill;
        logic [INDEX_BITS-1:0]    text_idx;
        bit                       found_flag;
        logic [POS_BITS-1:0]      first_pos;
        t_result                  pending_reports [$];
        int unsigned              errors;

        function new();
            len_reg    = 5'd1;
            pat_low    = '0;
            pat_high   = '0;
            offset_reg = '0;
            errors     = 0;
            clear_search();
        endfunction

        function void clear_search();
            foreach (window[k]) window[k] = '0;
            fill       = 0;
            text_idx   = '0;
            found_flag = 1'b0;
            first_pos  = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
            case (idx)
                REG_PATTERN_LENGTH: len_reg    = value[LEN_BITS-1:0];
                REG_PATTERN_LOW:    pat_low    = value;
                REG_PATTERN_HIGH:   pat_high   = value;
                REG_START_OFFSET:   offset_reg = value[INDEX_BITS-1:0];
                default: ;
            endcase
        endfunction

        function logic [BYTE_BITS-1:0] pat_byte(int unsigned k);
            if (k < 8) return pat_low[8*k +: 8];
            return pat_high[8*(k-8) +: 8];
        endfunction

        // Length zero acts as one, anything above the window saturates.
        function int unsigned active_len();
            if (len_reg == 0) return 1;
            if (len_reg > PATTERN_MAX) return PATTERN_MAX;
            return len_reg;
        endfunction

        function void note_byte(logic [BYTE_BITS-1:0] text_byte, logic text_last);
            int unsigned len;
            bit          hit;
            t_result     want;
            len = active_len();
            // Bytes ahead of the start offset never enter the window.
            if (text_idx >= offset_reg) begin
                for (int j = PATTERN_MAX - 1; j > 0; j--) window[j] = window[j-1];
                window[0] = text_byte;
                if (fill < PATTERN_MAX) fill++;
                if (fill >= len && !found_flag) begin
                    hit = 1'b1;
                    for (int unsigned j = 0; j < len; j++)
                        if (window[j] != pat_byte(len - 1 - j)) hit = 1'b0;
                    if (hit) begin
                        found_flag = 1'b1;
                        // A match ending on the saturated index reports the top value.
                        first_pos = (text_idx == INDEX_TOP) ? '1 : text_idx - (len - 1);
                    end
                end
            end
            if (text_idx != INDEX_TOP) text_idx++;
            want.found          = found_flag;
            want.match_position = found_flag ? first_pos : '0;
            want.done_res       = text_last;
            pending_reports.push_back(want);
            if (text_last) clear_search();
        endfunction

        function void flag(string what, logic [63:0] want, logic [63:0] got);
            errors++;
            if (errors <= REPORT_CAP)
                $display("%0t ns: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
        endfunction

        function void check_result(logic found, logic [POS_BITS-1:0] pos, logic done,
                                   logic [PAD_BITS-1:0] pad);
            t_result want;
            if (pending_reports.size() == 0) begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display("%0t ns: result word with none pending: expected none, actual %0h",
                             $time, {pad, pos, found});
                return;
            end
            want = pending_reports.pop_front();
            if (found !== want.found) flag("found", want.found, found);
            if (pos !== want.match_position) flag("match_position", want.match_position, pos);
            if (done !== want.done_res) flag("done (tlast)", want.done_res, done);
            if (pad !== '0) flag("tdata padding", 0, pad);
        endfunction
    endclass

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [7:0]               s_tdata   = '0;
    logic                     s_tlast   = 1'b0;
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic                     m_tlast;

    int          src_idle_pct   = 0;
    int          sink_stall_pct = 0;
    int unsigned cycle_count    = 0;
    int unsigned phase_items;

    match_tracker book = new();

    brute_force_substring_match_unit i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Result side: check every accepted word, then pick tready for the next edge.
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready)
            book.check_result(m_tdata[0], m_tdata[POS_BITS:1], m_tlast,
                              m_tdata[OUT_DATA_BITS-1:POS_BITS+1]);
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Watchdog: a hung handshake or a lost result ends here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Drive one config register; the unit must be idle.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        book.write_reg(idx, value);
    endtask

    // Send one text byte: optional idle gap, then hold the word until accepted.
    // tvalid stays high on return so back-to-back words need no second assignment.
    task automatic send_byte(input logic [7:0] text_byte, input logic text_last);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
        end
        s_tdata  <= text_byte;
        s_tlast  <= text_last;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        book.note_byte(text_byte, text_last);
    endtask

    // Drop tvalid and hold until every owed result word has come, plus a short pause
    // for the output register and skid stage.
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (book.pending_reports.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // One text of n bytes, built around the current pattern so that matches,
    // near misses and cut-off patterns all show up.
    task automatic send_text(input int unsigned n);
        logic [7:0]  txt [$];
        int unsigned len;
        int unsigned at;
        bit          narrow;
        len    = book.active_len();
        narrow = ($urandom_range(2) == 0);
        for (int unsigned i = 0; i < n; i++)
            txt.push_back(narrow ? book.pat_byte($urandom_range(len - 1)) : 8'($urandom));
        if ($urandom_range(99) < 60) begin
            at = $urandom_range(n - 1);
            for (int unsigned k = 0; k < len && at + k < n; k++) txt[at+k] = book.pat_byte(k);
        end
        foreach (txt[i]) begin
            // Now and then hold the sender mid-text until the result side is empty.
            if ($urandom_range(99) < 3) settle();
            send_byte(txt[i], i == txt.size() - 1);
            phase_items++;
        end
    endtask

    // New register set: mostly legal lengths, sometimes zero or oversize; a narrow
    // byte alphabet in some patterns makes overlapping matches common.
    task automatic setup_random();
        logic [CFG_DATA_BITS-1:0] value;
        bit                       narrow;
        narrow = ($urandom_range(2) == 0);
        value  = {$urandom, $urandom};
        case ($urandom_range(9))
            0:       value[LEN_BITS-1:0] = '0;
            1:       value[LEN_BITS-1:0] = LEN_BITS'($urandom_range(PATTERN_MAX + 1, 31));
            default: value[LEN_BITS-1:0] = LEN_BITS'($urandom_range(1, PATTERN_MAX));
        endcase
        write_reg(REG_PATTERN_LENGTH, value);
        for (int r = 0; r < 2; r++) begin
            value = {$urandom, $urandom};
            if (narrow)
                for (int k = 0; k < 8; k++) value[8*k +: 8] = 8'h41 + 8'(value[8*k]);
            write_reg((r == 0) ? REG_PATTERN_LOW : REG_PATTERN_HIGH, value);
        end
        value = {$urandom, $urandom};
        case ($urandom_range(9))
            0:       ;  // keep the full random offset, usually past the whole text
            1, 2:    value[INDEX_BITS-1:0] = INDEX_BITS'($urandom_range(1, 10));
            default: value[INDEX_BITS-1:0] = '0;
        endcase
        write_reg(REG_START_OFFSET, value);
        if ($urandom_range(3) == 0)
            write_reg(CFG_IDX_BITS'($urandom_range(REG_COUNT, 2**CFG_IDX_BITS - 1)),
                      {$urandom, $urandom});
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset registers: one-byte pattern of zero at offset zero.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);

        // Length zero behaves as one.
        settle();
        write_reg(REG_PATTERN_LENGTH, 64'd0);
        write_reg(REG_PATTERN_LOW, 64'h5A);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b1);

        // Two-byte pattern with the search starting one byte in.
        settle();
        write_reg(REG_PATTERN_LENGTH, 64'd2);
        write_reg(REG_PATTERN_LOW, 64'hBBAA);
        write_reg(REG_START_OFFSET, 64'd1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'hBB, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'hBB, 1'b1);

        // Registers rewritten in the middle of a text: the window carries over.
        settle();
        write_reg(REG_START_OFFSET, 64'd0);
        write_reg(REG_PATTERN_LENGTH, 64'd1);
        write_reg(REG_PATTERN_LOW, 64'h77);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        settle();
        write_reg(REG_PATTERN_LENGTH, 64'd3);
        write_reg(REG_PATTERN_LOW, 64'h443322);
        send_byte(8'h33, 1'b0);
        send_byte(8'h44, 1'b1);

        // Unused index ignored; oversize length saturates; offset at its top value.
        settle();
        write_reg(CFG_IDX_BITS'(REG_COUNT + 1), '1);
        write_reg(REG_PATTERN_LENGTH, 64'd31);
        write_reg(REG_PATTERN_LOW, '1);
        write_reg(REG_PATTERN_HIGH, '1);
        write_reg(REG_START_OFFSET, 64'hFFFF);
        for (int i = 0; i < 3; i++) send_byte(8'hFF, i == 2);
        settle();
        write_reg(REG_START_OFFSET, 64'd0);
        for (int i = 0; i < PATTERN_MAX; i++) send_byte(8'hFF, i == PATTERN_MAX - 1);

        // Random texts under each idling mix.
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            settle();
            case (ph)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 69; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 69; end
                default: begin src_idle_pct = 9; sink_stall_pct = 9; end
            endcase
            setup_random();
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE) begin
                send_text($urandom_range(1, 40));
                if ($urandom_range(3) == 0) begin
                    settle();
                    setup_random();
                end
            end
        end

        settle();
        repeat (16) @(posedge clk);
        if (book.errors == 0 && book.pending_reports.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
